/* src/sfb_pkg.sv */
`default_nettype none

package sfb_pkg;

  // Filter shape and field widths
  localparam int TAPS           = 33;
  localparam int CHANNELS       = 4;
  localparam int SAMPLE_WIDTH   = 24;
  localparam int CHANNEL_WIDTH  = 2;
  localparam int FILTERED_WIDTH = 25;

  localparam int HALF_TAPS  = TAPS / 2;
  localparam int HIST_CELLS = TAPS - 1;
  localparam int LEAVES     = HALF_TAPS + 1;

  // Only channels reachable through the channel field get storage
  localparam int CH_STORE     = (CHANNELS < (2 ** CHANNEL_WIDTH)) ? CHANNELS
                                                                  : (2 ** CHANNEL_WIDTH);
  localparam int CH_IDX_WIDTH = (CH_STORE > 1) ? $clog2(CH_STORE) : 1;

  // Datapath widths: absolute coefficient weight is 13070 < 2**14
  localparam int COEF_WIDTH = 12;
  localparam int COEF_SUM   = 6830;
  localparam int PAIR_WIDTH = SAMPLE_WIDTH + 1;
  localparam int PROD_WIDTH = PAIR_WIDTH + COEF_WIDTH;
  localparam int ACC_WIDTH  = SAMPLE_WIDTH + 14;
  localparam int MAG_WIDTH  = ACC_WIDTH - 1;

  // Long division by the coefficient sum, DIV_BITS quotient bits per cell
  localparam int REM_WIDTH  = $clog2(COEF_SUM);
  localparam logic [REM_WIDTH:0] DIVISOR = (REM_WIDTH + 1)'(COEF_SUM);
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = (MAG_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int NQ_WIDTH   = DIV_STAGES * DIV_BITS;

  // Coefficient of leaf i: mirrored pairs first, the centre tap last
  function automatic logic signed [COEF_WIDTH-1:0] coef_tap(input int i);
    logic signed [COEF_WIDTH-1:0] c;
    case (i)
      0:       c = COEF_WIDTH'(-23);
      1:       c = COEF_WIDTH'(-16);
      2:       c = COEF_WIDTH'(-5);
      3:       c = COEF_WIDTH'(9);
      4:       c = COEF_WIDTH'(16);
      5:       c = COEF_WIDTH'(-4);
      6:       c = COEF_WIDTH'(-70);
      7:       c = COEF_WIDTH'(-184);
      8:       c = COEF_WIDTH'(-317);
      9:       c = COEF_WIDTH'(-406);
      10:      c = COEF_WIDTH'(-374);
      11:      c = COEF_WIDTH'(-161);
      12:      c = COEF_WIDTH'(241);
      13:      c = COEF_WIDTH'(770);
      14:      c = COEF_WIDTH'(1306);
      15:      c = COEF_WIDTH'(1706);
      16:      c = COEF_WIDTH'(1854);
      default: c = '0;
    endcase
    return c;
  endfunction

  // Adder tree geometry: level sizes and offsets in the flat node array
  function automatic int tree_size(input int lvl);
    return (LEAVES + (1 << lvl) - 1) >> lvl;
  endfunction

  function automatic int tree_base(input int lvl);
    int b;
    b = 0;
    for (int k = 0; k < lvl; k++) begin
      b += tree_size(k);
    end
    return b;
  endfunction

  localparam int TREE_LEVELS = $clog2(LEAVES);
  localparam int TREE_NODES  = tree_base(TREE_LEVELS + 1);

  // Sideband that follows each sample down the pipeline
  typedef struct packed {
    logic                     live;
    logic [CHANNEL_WIDTH-1:0] channel;
  } ctl_t;

  // Divider cell state
  typedef struct packed {
    logic [REM_WIDTH-1:0] rem;
    logic [NQ_WIDTH-1:0]  nq;
    logic                 neg;
    ctl_t                 ctl;
  } div_t;

endpackage

`default_nettype wire

/* src/sfb_if.sv */
`default_nettype none

// Sample stream into the filter
interface sfb_in_if;
  import sfb_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;
  logic [CHANNEL_WIDTH-1:0]       channel;

  modport source (output valid, output sample, output channel, input ready);
  modport sink   (input valid, input sample, input channel, output ready);
endinterface

// Filtered result stream
interface sfb_out_if;
  import sfb_pkg::*;

  logic                             valid;
  logic                             ready;
  logic signed [FILTERED_WIDTH-1:0] filtered;
  logic [CHANNEL_WIDTH-1:0]         channel_out;

  modport source (output valid, output filtered, output channel_out, input ready);
  modport sink   (input valid, input filtered, input channel_out, output ready);
endinterface

`default_nettype wire

/* src/sfb_tap_cell.sv */
`default_nettype none

module sfb_tap_cell (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    shift_i,
  input  logic [sfb_pkg::CH_IDX_WIDTH-1:0]        chan_i,
  input  logic signed [sfb_pkg::SAMPLE_WIDTH-1:0] sample_i,
  output logic signed [sfb_pkg::SAMPLE_WIDTH-1:0] sample_o
);
  import sfb_pkg::*;

  // One delay slot per channel
  logic signed [SAMPLE_WIDTH-1:0] hist_q [CH_STORE];

  // Take the neighbor's sample for the active channel on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CH_STORE; c++) begin
        hist_q[c] <= '0;
      end
    end else if (shift_i) begin
      hist_q[chan_i] <= sample_i;
    end
  end

  // Hand this slot's sample to the next cell and the tree
  assign sample_o = hist_q[chan_i];

endmodule

`default_nettype wire

/* src/sfb_mac.sv */
`default_nettype none

module sfb_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  logic signed [sfb_pkg::SAMPLE_WIDTH-1:0] window_i [sfb_pkg::TAPS],
  input  sfb_pkg::ctl_t                           ctl_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic signed [sfb_pkg::ACC_WIDTH-1:0]    sum_o,
  output sfb_pkg::ctl_t                           ctl_o
);
  import sfb_pkg::*;

  // Stage 0 folds pairs, stage 1 multiplies, then one stage per tree level
  localparam int NumStages = TREE_LEVELS + 2;

  logic [NumStages-1:0]         stage_en;
  logic [NumStages-1:0]         valid_q;
  ctl_t                         ctl_q   [NumStages];
  logic signed [PAIR_WIDTH-1:0] pair_q  [LEAVES];
  logic signed [ACC_WIDTH-1:0]  node_q  [TREE_NODES];

  // A stage loads when it is empty or its successor moves
  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      stage_en[s] = !valid_q[s] || stage_en[s+1];
    end
  end

  assign ready_o = stage_en[0];
  assign valid_o = valid_q[NumStages-1];
  assign ctl_o   = ctl_q[NumStages-1];
  assign sum_o   = node_q[TREE_NODES-1];

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (stage_en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // Sideband
  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      ctl_q[0] <= ctl_i;
    end
    for (int s = 1; s < NumStages; s++) begin
      if (stage_en[s]) begin
        ctl_q[s] <= ctl_q[s-1];
      end
    end
  end

  // Fold mirrored taps; the centre tap passes alone
  for (genvar i = 0; i < LEAVES; i++) begin : g_pair
    if (i < HALF_TAPS) begin : g_fold
      always_ff @(posedge clk_i) begin
        if (stage_en[0]) begin
          pair_q[i] <= PAIR_WIDTH'(window_i[i]) + PAIR_WIDTH'(window_i[TAPS-1-i]);
        end
      end
    end else begin : g_centre
      always_ff @(posedge clk_i) begin
        if (stage_en[0]) begin
          pair_q[i] <= PAIR_WIDTH'(window_i[i]);
        end
      end
    end
  end

  // Constant multiply into the tree leaves
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    localparam logic signed [PROD_WIDTH-1:0] Coef = PROD_WIDTH'(coef_tap(i));
    logic signed [PROD_WIDTH-1:0] prod;

    assign prod = PROD_WIDTH'(pair_q[i]) * Coef;

    always_ff @(posedge clk_i) begin
      if (stage_en[1]) begin
        node_q[i] <= ACC_WIDTH'(prod);
      end
    end
  end

  // Registered pairwise adder tree; an odd node passes through
  for (genvar l = 1; l <= TREE_LEVELS; l++) begin : g_lvl
    localparam int Base     = tree_base(l);
    localparam int PrevBase = tree_base(l - 1);
    localparam int PrevSize = tree_size(l - 1);

    for (genvar j = 0; j < tree_size(l); j++) begin : g_node
      if (2 * j + 1 < PrevSize) begin : g_add
        always_ff @(posedge clk_i) begin
          if (stage_en[l+1]) begin
            node_q[Base+j] <= node_q[PrevBase+2*j] + node_q[PrevBase+2*j+1];
          end
        end
      end else begin : g_pass
        always_ff @(posedge clk_i) begin
          if (stage_en[l+1]) begin
            node_q[Base+j] <= node_q[PrevBase+2*j];
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/sfb_div_cell.sv */
`default_nettype none

module sfb_div_cell (
  input  logic          clk_i,
  input  logic          load_i,
  input  sfb_pkg::div_t cell_i,
  output sfb_pkg::div_t cell_o
);
  import sfb_pkg::*;

  div_t               step;
  logic [REM_WIDTH:0] trial;

  // Restoring division, DIV_BITS quotient bits; quotient bits shift in
  // behind the dividend bits as they are consumed
  always_comb begin
    step  = cell_i;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial   = {step.rem, step.nq[NQ_WIDTH-1]};
      step.nq = {step.nq[NQ_WIDTH-2:0], 1'b0};
      if (trial >= DIVISOR) begin
        step.rem   = REM_WIDTH'(trial - DIVISOR);
        step.nq[0] = 1'b1;
      end else begin
        step.rem = trial[REM_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      cell_o <= step;
    end
  end

endmodule

`default_nettype wire

/* src/sfb_div.sv */
`default_nettype none

module sfb_div (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic signed [sfb_pkg::ACC_WIDTH-1:0]      sum_i,
  input  sfb_pkg::ctl_t                             ctl_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output logic signed [sfb_pkg::FILTERED_WIDTH-1:0] filtered_o,
  output logic [sfb_pkg::CHANNEL_WIDTH-1:0]         channel_o
);
  import sfb_pkg::*;

  // Sign split, DIV_STAGES division cells, then the output register
  localparam int NumStages = DIV_STAGES + 2;

  logic [NumStages-1:0]             stage_en;
  logic [NumStages-1:0]             valid_q;
  div_t                             cell_q [DIV_STAGES+1];
  div_t                             head;
  logic                             sum_neg;
  logic [MAG_WIDTH-1:0]             mag_full;
  logic [FILTERED_WIDTH-1:0]        quot;
  logic signed [FILTERED_WIDTH-1:0] filtered_d;
  logic signed [FILTERED_WIDTH-1:0] filtered_q;
  logic [CHANNEL_WIDTH-1:0]         channel_q;

  // Stage enables
  always_comb begin
    stage_en[NumStages-1] = !valid_q[NumStages-1] || ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      stage_en[s] = !valid_q[s] || stage_en[s+1];
    end
  end

  assign ready_o    = stage_en[0];
  assign valid_o    = valid_q[NumStages-1];
  assign filtered_o = filtered_q;
  assign channel_o  = channel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (stage_en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // Divide the magnitude so the quotient truncates toward zero
  assign sum_neg  = sum_i[ACC_WIDTH-1];
  assign mag_full = MAG_WIDTH'(sum_neg ? $unsigned(-sum_i) : $unsigned(sum_i));

  always_comb begin
    head.rem = '0;
    head.nq  = NQ_WIDTH'(mag_full);
    head.neg = sum_neg;
    head.ctl = ctl_i;
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      cell_q[0] <= head;
    end
  end

  // Chain of division cells
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_cell
    sfb_div_cell u_cell (
      .clk_i  (clk_i),
      .load_i (stage_en[k+1]),
      .cell_i (cell_q[k]),
      .cell_o (cell_q[k+1])
    );
  end

  // Restore the sign; an absent channel reads as zero
  assign quot = FILTERED_WIDTH'(cell_q[DIV_STAGES].nq);

  always_comb begin
    if (!cell_q[DIV_STAGES].ctl.live) begin
      filtered_d = '0;
    end else if (cell_q[DIV_STAGES].neg) begin
      filtered_d = $signed(-quot);
    end else begin
      filtered_d = $signed(quot);
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (stage_en[NumStages-1]) begin
      filtered_q <= filtered_d;
      channel_q  <= cell_q[DIV_STAGES].ctl.channel;
    end
  end

endmodule

`default_nettype wire

/* src/symmetric_fir_bandpass.sv */
// 33-tap linear-phase band-pass FIR (0.5 to 5 Hz at 50 Hz) for up to four
// interleaved sensor channels, each with its own 32-sample history.
//
// in_i  : sample stream (sample, channel); a transfer happens when valid
//         and ready are both high. Samples of different channels may be
//         interleaved freely.
// out_o : one result per sample (filtered, channel_out), in input order.
//         filtered is the folded filter sum divided by 6830, truncated
//         toward zero.
// Throughput: one sample per cycle, sustained while out_o.ready stays high.
// Pipeline: the fold and multiply registers, the registered adder tree
//   (5 levels), then the sign split, the division chain of ten 4-bit cells
//   and the output register.
// Reset: all channel histories clear to zero and the pipeline empties.
// Stall: when out_o.ready is low the result holds; stages behind it keep
//   advancing into empty slots, and in_i.ready drops only once every stage
//   holds a sample.
`default_nettype none

module symmetric_fir_bandpass (
  input  logic      clk_i,
  input  logic      rst_ni,
  sfb_in_if.sink    in_i,
  sfb_out_if.source out_o
);
  import sfb_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] window [TAPS];
  logic [CH_IDX_WIDTH-1:0]        chan_idx;
  logic                           chan_live;
  logic                           shift;
  ctl_t                           in_ctl;
  logic                           mac_ready;
  logic                           mac_valid;
  logic signed [ACC_WIDTH-1:0]    mac_sum;
  ctl_t                           mac_ctl;
  logic                           div_ready;

  // Channel decode; a channel without storage leaves the history alone
  assign chan_idx  = in_i.channel[CH_IDX_WIDTH-1:0];
  assign chan_live = (int'(in_i.channel) < CHANNELS);
  assign shift     = in_i.valid && mac_ready && chan_live;

  assign in_i.ready     = mac_ready;
  assign in_ctl.live    = chan_live;
  assign in_ctl.channel = in_i.channel;

  // Delay line: window[0] is the new sample, window[k] the one k steps old
  assign window[0] = in_i.sample;

  for (genvar k = 0; k < HIST_CELLS; k++) begin : g_tap
    sfb_tap_cell u_tap (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .chan_i   (chan_idx),
      .sample_i (window[k]),
      .sample_o (window[k+1])
    );
  end

  // Folded multiply-accumulate
  sfb_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .ready_o  (mac_ready),
    .window_i (window),
    .ctl_i    (in_ctl),
    .valid_o  (mac_valid),
    .ready_i  (div_ready),
    .sum_o    (mac_sum),
    .ctl_o    (mac_ctl)
  );

  // Scale by the coefficient sum
  sfb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (mac_valid),
    .ready_o    (div_ready),
    .sum_i      (mac_sum),
    .ctl_i      (mac_ctl),
    .valid_o    (out_o.valid),
    .ready_i    (out_o.ready),
    .filtered_o (out_o.filtered),
    .channel_o  (out_o.channel_out)
  );

endmodule

`default_nettype wire
